### hw/rtl/swfe_pkg.sv
// ----------------------------------------------------------------------------
// swfe_pkg
// Shared types, constants and ring index helpers for the sync word frame
// extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package swfe_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int MAX_FRAME  = 64;

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int LEN_W  = $clog2(MAX_FRAME + 1);
  localparam int WIDE_W = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

  localparam logic [7:0] SYNC_A     = 8'hEB;
  localparam logic [7:0] SYNC_B     = 8'h90;
  localparam logic [7:0] SUM_OK     = 8'h00;
  localparam logic [7:0] MIN_FRAME  = 8'd5;
  localparam int         MIN_BUFFER = 4;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] off_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [7:0]  function_code;
    logic [15:0] frame_total;
  } out_t;

  typedef struct packed {
    logic       we;
    idx_t       waddr;
    logic [7:0] wdata;
    idx_t       raddr;
  } ring_req_t;

  function automatic idx_t ring_add(input idx_t base, input off_t off);
    logic [WIDE_W-1:0] s;
    s = WIDE_W'(base) + WIDE_W'(off);
    if (s >= WIDE_W'(RING_DEPTH)) s = s - WIDE_W'(RING_DEPTH);
    return s[IDX_W-1:0];
  endfunction

  function automatic idx_t ring_count(input idx_t wr, input idx_t rd);
    logic [WIDE_W-1:0] s;
    if (wr >= rd) s = WIDE_W'(wr) - WIDE_W'(rd);
    else          s = WIDE_W'(wr) + WIDE_W'(RING_DEPTH) - WIDE_W'(rd);
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/swfe_ring.sv
// ----------------------------------------------------------------------------
// swfe_ring
// Byte ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swfe_ring
  import swfe_pkg::*;
(
  input  wire logic      clk,
  input  wire ring_req_t req,
  output logic [7:0]     rdata
);

  logic [7:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/swfe_ctrl.sv
// ----------------------------------------------------------------------------
// swfe_ctrl
// Command sequencer: ring indices, header scan, checksum pass and frame
// emission, with registered result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module swfe_ctrl
  import swfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire in_t        cmd,
  output logic            busy,
  output ring_req_t       req,
  input  wire logic [7:0] rdata,
  output out_t            result,
  output logic            strobe
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_SCAN = 10'b00_0000_0010,
    ST_H0   = 10'b00_0000_0100,
    ST_H1   = 10'b00_0000_1000,
    ST_H2   = 10'b00_0001_0000,
    ST_H3   = 10'b00_0010_0000,
    ST_SUM  = 10'b00_0100_0000,
    ST_CHK  = 10'b00_1000_0000,
    ST_EMIT = 10'b01_0000_0000,
    ST_NONE = 10'b10_0000_0000
  } state_t;

  state_t      state, state_next;
  idx_t        rd, rd_next;
  idx_t        wr, wr_next;
  logic [15:0] frames, frames_next;
  logic [7:0]  func, func_next;
  logic [7:0]  len_q, len_next;
  off_t        cnt, cnt_next;
  logic [7:0]  sum, sum_next;
  out_t        result_next;
  logic        strobe_next;
  off_t        off;
  idx_t        count;
  logic        is_last;

  assign count   = ring_count(wr, rd);
  assign is_last = (cnt == (len_q[LEN_W-1:0] - LEN_W'(1)));
  assign busy    = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    rd_next     = rd;
    wr_next     = wr;
    frames_next = frames;
    func_next   = func;
    len_next    = len_q;
    cnt_next    = cnt;
    sum_next    = sum;
    result_next = result;
    strobe_next = 1'b0;
    off         = '0;
    req.we      = 1'b0;
    req.waddr   = wr;
    req.wdata   = cmd.rx_byte;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd.operation == OP_PUSH) begin
            if (count != IDX_W'(RING_DEPTH - 1)) begin
              req.we  = 1'b1;
              wr_next = ring_add(wr, LEN_W'(1));
            end
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (count > IDX_W'(MIN_BUFFER)) state_next = ST_H0;
        else                            state_next = ST_NONE;
      end
      ST_H0: begin
        if (rdata == SYNC_A) begin
          off        = LEN_W'(1);
          state_next = ST_H1;
        end else begin
          rd_next    = ring_add(rd, LEN_W'(1));
          state_next = ST_SCAN;
        end
      end
      ST_H1: begin
        if (rdata == SYNC_B) begin
          off        = LEN_W'(2);
          state_next = ST_H2;
        end else begin
          rd_next    = ring_add(rd, LEN_W'(1));
          state_next = ST_SCAN;
        end
      end
      ST_H2: begin
        len_next   = rdata;
        off        = LEN_W'(3);
        state_next = ST_H3;
      end
      ST_H3: begin
        func_next = rdata;
        if (len_q < MIN_FRAME || len_q > 8'(MAX_FRAME)) begin
          rd_next    = ring_add(rd, LEN_W'(2));
          state_next = ST_SCAN;
        end else if (WIDE_W'(count) < WIDE_W'(len_q[LEN_W-1:0])) begin
          state_next = ST_NONE;
        end else begin
          cnt_next   = '0;
          sum_next   = '0;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_next = sum + rdata;
        off      = cnt + LEN_W'(1);
        if (is_last) state_next = ST_CHK;
        else         cnt_next   = cnt + LEN_W'(1);
      end
      ST_CHK: begin
        if (sum != SUM_OK) begin
          rd_next    = ring_add(rd, LEN_W'(2));
          state_next = ST_SCAN;
        end else begin
          frames_next = frames + 16'd1;
          cnt_next    = '0;
          state_next  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        strobe_next               = 1'b1;
        result_next.found         = 1'b1;
        result_next.frame_byte    = rdata;
        result_next.last_byte     = is_last;
        result_next.function_code = func;
        result_next.frame_total   = frames;
        off                       = cnt + LEN_W'(1);
        if (is_last) begin
          rd_next    = ring_add(rd, len_q[LEN_W-1:0]);
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + LEN_W'(1);
        end
      end
      ST_NONE: begin
        strobe_next               = 1'b1;
        result_next.found         = 1'b0;
        result_next.frame_byte    = 8'd0;
        result_next.last_byte     = 1'b1;
        result_next.function_code = func;
        result_next.frame_total   = frames;
        state_next                = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    req.raddr = ring_add(rd, off);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd     <= '0;
      wr     <= '0;
      frames <= '0;
      func   <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      rd     <= rd_next;
      wr     <= wr_next;
      frames <= frames_next;
      func   <= func_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    len_q  <= len_next;
    cnt    <= cnt_next;
    sum    <= sum_next;
    result <= result_next;
  end

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.found |-> result.last_byte)
    else $error("no-frame beat without last mark");

  a_pull_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.operation == OP_PULL |=> busy)
    else $error("pull accepted but sequencer idle");

  a_push_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.operation == OP_PUSH |=> !busy && !strobe)
    else $error("push produced a beat or stayed busy");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> WIDE_W'(cnt) < WIDE_W'(len_q))
    else $error("emit index beyond frame length");

endmodule

`default_nettype wire

### hw/rtl/sync_word_frame_extractor_top.sv
// ----------------------------------------------------------------------------
// sync_word_frame_extractor_top
// Ring-buffered deframer: finds EB 90 sync headers, checks length and
// byte sum, and emits valid frames one byte per beat.
//
//   channel   handshake             payload
//   command   start / busy          cmd    (operation, rx_byte)
//   result    strobe (no stall)     result (found, frame_byte, last_byte,
//                                           function_code, frame_total)
//
// A push stores one byte if the ring has room. A pull walks the ring through the
// single read port: scan and header reads per skipped byte, the header, the sum
// pass, a check and the len beats; a short buffer or an incomplete frame gives a
// no-frame result. Beats are registered and appear in the cycle after their step.
// Reset clears indices, frame count and function code; ring contents are left.
// Result beats cannot be held off; busy covers the walk but not the final beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_word_frame_extractor_top
  import swfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire in_t  cmd,
  output logic      busy,
  output out_t      result,
  output logic      strobe
);

  ring_req_t  req;
  logic [7:0] rdata;

  swfe_ring u_ring (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  swfe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .req    (req),
    .rdata  (rdata),
    .result (result),
    .strobe (strobe)
  );

endmodule

`default_nettype wire
